[rtl/core/ksel_pkg.sv]
// Shared types and constants for the k-th smallest index select core.
// Holds the controller command codes, the datapath status group and the
// generator constants. No dependencies.
package ksel_pkg;

  localparam int MAX_ITEMS_DEF   = 1024;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int SAMPLE_W        = 32;
  localparam int RANK_W          = 12;
  localparam int POS_W           = 10;
  localparam int STAT_W          = 2;
  localparam int IN_DATA_W       = 48;
  localparam int OUT_DATA_W      = 16;

  localparam logic [63:0] SEED_RESET = 64'd88172645463325252;
  localparam logic [63:0] MIX_MULT   = 64'h2545F4914F6CDD1D;

  localparam logic [STAT_W-1:0] ST_FOUND = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVF   = 2'd2;

  // Datapath commands, one per controller step
  typedef enum logic [4:0] {
    CMD_LOAD,
    CMD_DECIDE,
    CMD_SCAN,
    CMD_INIT,
    CMD_RAND,
    CMD_MUL,
    CMD_MOD,
    CMD_PIV_RD,
    CMD_PIV_CAP,
    CMD_PIV_SW1,
    CMD_PIV_SW2,
    CMD_PART_RD,
    CMD_PART_VAL,
    CMD_PART_CMP,
    CMD_PART_SW,
    CMD_FIN_RD,
    CMD_FIN_CAP,
    CMD_FIN_SW1,
    CMD_FIN_SW2,
    CMD_CHECK,
    CMD_LAST_RD,
    CMD_LAST_CAP,
    CMD_OUT
  } cmd_t;

  typedef struct packed {
    logic err;        // overflow or rank out of range
    logic single;     // one element in the set
    logic first;      // rank is the first position
    logic last_rank;  // rank is the last position
    logic scan_done;
    logic init_last;
    logic bit_last;   // serial multiply or reduce on its final step
    logic part_end;   // partition cursor reached the right bound
    logic less;       // current key below the pivot key
    logic hit;        // pivot landed on the target
    logic more_left;  // left bound still below right bound
    logic out_free;
  } stat_t;

endpackage

[rtl/core/kth_smallest_index_select_core.sv]
// Top level of the k-th smallest index select core.
// Joins ksel_ctrl and ksel_dp; depends on ksel_pkg.
//
// Streams signed values in, one transfer per clock while idle, and closes the
// set on the transfer with tlast; the rank in that transfer picks the element
// (0 median, positive from the start counting from 1, negative from the end).
// One result transfer follows each set: tuser carries the status (found, rank
// out of range, set larger than the store) and tdata the arrival position.
// Loading is bounded by the single write port of the value store. Selection
// time after the last item depends on the data: a first or last rank is a
// linear scan of the value store; any other rank first fills the index store,
// then each quickselect round draws a pivot (one xorshift step, a 64-step
// serial multiply and a 64-step serial reduce modulo the span), swaps it to
// the right bound, partitions the span one element at a time, paced by the
// single read port of the index store, and places the pivot and narrows the
// bounds. The result sits in an output register, so the next set may load
// while it waits to be taken.
module kth_smallest_index_select_core #(
  parameter int MAX_ITEMS   = ksel_pkg::MAX_ITEMS_DEF,
  parameter int VALUE_WIDTH = ksel_pkg::VALUE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [ksel_pkg::IN_DATA_W-1:0]   s_tdata,  // sample_value[31:0], rank_k[43:32]
  input  logic                             s_tlast,  // last_item
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [ksel_pkg::OUT_DATA_W-1:0]  m_tdata,  // result_index[9:0]
  output logic [ksel_pkg::STAT_W-1:0]      m_tuser   // status[1:0]
);

  ksel_pkg::cmd_t  cmd;
  ksel_pkg::stat_t st;

  // Sequence loading, rank decode, scan or quickselect, and result hand-off
  ksel_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tlast(s_tlast),
    .st(st), .s_tready(s_tready), .cmd(cmd)
  );

  // Hold the stores, pivot generator and the result register
  ksel_dp #(.MAX_ITEMS(MAX_ITEMS), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .s_tvalid(s_tvalid), .s_tdata(s_tdata),
    .s_tlast(s_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .st(st)
  );

endmodule

[rtl/core/ksel_ram.sv]
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module ksel_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/ksel_ctrl.sv]
// Controller state machine for the k-th smallest index select core.
// Depends on ksel_pkg for command codes and the status group.
module ksel_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tlast,
  input  ksel_pkg::stat_t  st,
  output logic             s_tready,
  output ksel_pkg::cmd_t   cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_DECIDE, S_SCAN, S_INIT, S_RAND, S_MUL, S_MOD,
    S_P0, S_P1, S_P2, S_P3, S_L0, S_L1, S_L2, S_L3,
    S_F0, S_F1, S_F2, S_F3, S_CHK, S_LAST0, S_LAST1, S_OUT
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (s_tvalid && s_tlast) state_next = S_DECIDE;
      S_DECIDE: begin
        if (st.err || st.single) state_next = S_OUT;
        else if (st.first || st.last_rank) state_next = S_SCAN;
        else state_next = S_INIT;
      end
      S_SCAN:   if (st.scan_done) state_next = S_OUT;
      S_INIT:   if (st.init_last) state_next = S_RAND;
      S_RAND:   state_next = S_MUL;
      S_MUL:    if (st.bit_last) state_next = S_MOD;
      S_MOD:    if (st.bit_last) state_next = S_P0;
      S_P0:     state_next = S_P1;
      S_P1:     state_next = S_P2;
      S_P2:     state_next = S_P3;
      S_P3:     state_next = S_L0;
      S_L0:     state_next = st.part_end ? S_F0 : S_L1;
      S_L1:     state_next = S_L2;
      S_L2:     state_next = st.less ? S_L3 : S_L0;
      S_L3:     state_next = S_L0;
      S_F0:     state_next = S_F1;
      S_F1:     state_next = S_F2;
      S_F2:     state_next = S_F3;
      S_F3:     state_next = st.hit ? S_OUT : S_CHK;
      S_CHK:    state_next = st.more_left ? S_RAND : S_LAST0;
      S_LAST0:  state_next = S_LAST1;
      S_LAST1:  state_next = S_OUT;
      S_OUT:    if (st.out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    unique case (state)
      S_IDLE:   cmd = ksel_pkg::CMD_LOAD;
      S_DECIDE: cmd = ksel_pkg::CMD_DECIDE;
      S_SCAN:   cmd = ksel_pkg::CMD_SCAN;
      S_INIT:   cmd = ksel_pkg::CMD_INIT;
      S_RAND:   cmd = ksel_pkg::CMD_RAND;
      S_MUL:    cmd = ksel_pkg::CMD_MUL;
      S_MOD:    cmd = ksel_pkg::CMD_MOD;
      S_P0:     cmd = ksel_pkg::CMD_PIV_RD;
      S_P1:     cmd = ksel_pkg::CMD_PIV_CAP;
      S_P2:     cmd = ksel_pkg::CMD_PIV_SW1;
      S_P3:     cmd = ksel_pkg::CMD_PIV_SW2;
      S_L0:     cmd = ksel_pkg::CMD_PART_RD;
      S_L1:     cmd = ksel_pkg::CMD_PART_VAL;
      S_L2:     cmd = ksel_pkg::CMD_PART_CMP;
      S_L3:     cmd = ksel_pkg::CMD_PART_SW;
      S_F0:     cmd = ksel_pkg::CMD_FIN_RD;
      S_F1:     cmd = ksel_pkg::CMD_FIN_CAP;
      S_F2:     cmd = ksel_pkg::CMD_FIN_SW1;
      S_F3:     cmd = ksel_pkg::CMD_FIN_SW2;
      S_CHK:    cmd = ksel_pkg::CMD_CHECK;
      S_LAST0:  cmd = ksel_pkg::CMD_LAST_RD;
      S_LAST1:  cmd = ksel_pkg::CMD_LAST_CAP;
      S_OUT:    cmd = ksel_pkg::CMD_OUT;
      default:  cmd = ksel_pkg::CMD_CHECK;
    endcase
  end

  assign s_tready = (state == S_IDLE);

endmodule

[rtl/core/ksel_dp.sv]
// Datapath of the k-th smallest index select core: value and index stores,
// pivot generator with serial multiply and reduce, partition registers, output
// register. Depends on ksel_pkg and ksel_ram.
module ksel_dp #(
  parameter int MAX_ITEMS   = ksel_pkg::MAX_ITEMS_DEF,
  parameter int VALUE_WIDTH = ksel_pkg::VALUE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ksel_pkg::cmd_t                    cmd,
  input  logic                              s_tvalid,
  input  logic [ksel_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [ksel_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic [ksel_pkg::STAT_W-1:0]       m_tuser,
  output ksel_pkg::stat_t                   st
);

  localparam int IW = $clog2(MAX_ITEMS);
  localparam int CW = IW + 1;
  localparam int RW = ksel_pkg::RANK_W;
  localparam int TW = ((CW > RW) ? CW : RW) + 2;
  localparam logic [VALUE_WIDTH-1:0] SIGN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  logic [CW-1:0]          count;
  logic                   ovf;
  logic signed [RW-1:0]   rank_reg;
  logic [IW-1:0]          tgt, left, right, cur, store, pidx;
  logic [IW-1:0]          a_reg, b_reg, x_reg;
  logic [VALUE_WIDTH-1:0] pkey, best_key;
  logic [63:0]            seed, acc, mcand, mplier;
  logic [5:0]             bitcnt;
  logic [IW-1:0]          rem;
  logic [CW-1:0]          cnt_i;
  logic                   p1;
  logic [IW-1:0]          p1_pos;
  logic                   scan_max;
  logic [ksel_pkg::STAT_W-1:0] res_status, out_status;
  logic [IW-1:0]          res_pos;
  logic [ksel_pkg::POS_W-1:0] out_pos;

  logic                   idx_we, val_we;
  logic [IW-1:0]          idx_waddr, idx_wdata, idx_raddr, idx_rdata;
  logic [IW-1:0]          val_raddr;
  logic [VALUE_WIDTH-1:0] val_wdata, val_rdata, key_rd;

  logic signed [TW-1:0]   rank_s, n_s, target;
  logic                   out_range, load_fire, room, out_free, lt;
  logic [63:0]            xs1, xs2, xs3;
  logic [CW-1:0]          span, trial;

  ksel_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_ITEMS)) u_val_ram (
    .clk(clk), .we(val_we), .waddr(count[IW-1:0]), .wdata(val_wdata),
    .raddr(val_raddr), .rdata(val_rdata)
  );

  ksel_ram #(.WIDTH(IW), .DEPTH(MAX_ITEMS)) u_idx_ram (
    .clk(clk), .we(idx_we), .waddr(idx_waddr), .wdata(idx_wdata),
    .raddr(idx_raddr), .rdata(idx_rdata)
  );

  assign room      = (count < CW'(MAX_ITEMS));
  assign load_fire = (cmd == ksel_pkg::CMD_LOAD) && s_tvalid;
  assign val_we    = load_fire && room;
  assign val_wdata = VALUE_WIDTH'(s_tdata[ksel_pkg::SAMPLE_W-1:0]);
  assign key_rd    = val_rdata ^ SIGN;
  assign lt        = key_rd < pkey;
  assign out_free  = !m_tvalid || m_tready;

  // Rank to zero-based target
  always_comb begin
    rank_s = {{(TW-RW){rank_reg[RW-1]}}, rank_reg};
    n_s    = {{(TW-CW){1'b0}}, count};
    if (rank_s > 0) target = rank_s - TW'(1);
    else if (rank_s < 0) target = n_s + rank_s;
    else target = n_s >>> 1;
    out_range = (target < 0) || (target >= n_s);
  end

  // xorshift64 update
  always_comb begin
    xs1 = seed ^ (seed >> 12);
    xs2 = xs1 ^ (xs1 << 25);
    xs3 = xs2 ^ (xs2 >> 27);
  end

  assign span  = {1'b0, right} - {1'b0, left} + CW'(1);
  assign trial = {rem, acc[63]};

  always_comb begin
    idx_raddr = cur;
    val_raddr = cnt_i[IW-1:0];
    unique case (cmd)
      ksel_pkg::CMD_PIV_RD:   idx_raddr = left + rem;
      ksel_pkg::CMD_PIV_CAP:  begin
        idx_raddr = right;
        val_raddr = idx_rdata;
      end
      ksel_pkg::CMD_PART_VAL: begin
        idx_raddr = store;
        val_raddr = idx_rdata;
      end
      ksel_pkg::CMD_FIN_RD:   idx_raddr = store;
      ksel_pkg::CMD_FIN_CAP:  idx_raddr = right;
      ksel_pkg::CMD_LAST_RD:  idx_raddr = left;
      default:                idx_raddr = cur;
    endcase
  end

  always_comb begin
    idx_we    = 1'b0;
    idx_waddr = cur;
    idx_wdata = idx_rdata;
    unique case (cmd)
      ksel_pkg::CMD_INIT: begin
        idx_we    = 1'b1;
        idx_waddr = cnt_i[IW-1:0];
        idx_wdata = cnt_i[IW-1:0];
      end
      ksel_pkg::CMD_PIV_SW1: begin
        idx_we    = 1'b1;
        idx_waddr = pidx;
      end
      ksel_pkg::CMD_PIV_SW2, ksel_pkg::CMD_FIN_SW2: begin
        idx_we    = 1'b1;
        idx_waddr = right;
        idx_wdata = a_reg;
      end
      ksel_pkg::CMD_PART_CMP: idx_we = lt;
      ksel_pkg::CMD_PART_SW: begin
        idx_we    = 1'b1;
        idx_waddr = store;
        idx_wdata = x_reg;
      end
      ksel_pkg::CMD_FIN_SW1: begin
        idx_we    = 1'b1;
        idx_waddr = store;
      end
      default: idx_we = 1'b0;
    endcase
  end

  always_comb begin
    st.err       = ovf || out_range;
    st.single    = (count == CW'(1));
    st.first     = (target == 0);
    st.last_rank = (target == n_s - TW'(1));
    st.scan_done = (cnt_i == count) && !p1;
    st.init_last = (cnt_i == count - CW'(1));
    st.bit_last  = (bitcnt == 6'd63);
    st.part_end  = (cur == right);
    st.less      = lt;
    st.hit       = (tgt == store);
    st.more_left = (left < right);
    st.out_free  = out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      ovf      <= 1'b0;
      seed     <= ksel_pkg::SEED_RESET;
      left     <= '0;
      right    <= '0;
      m_tvalid <= 1'b0;
      p1       <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one replaces it this cycle
      if (m_tvalid && m_tready && (cmd != ksel_pkg::CMD_OUT)) begin
        m_tvalid <= 1'b0;
      end
      case (cmd)
        ksel_pkg::CMD_LOAD: begin
          if (s_tvalid) begin
            if (room) count <= count + CW'(1);
            else ovf <= 1'b1;
            if (s_tlast) rank_reg <= s_tdata[ksel_pkg::SAMPLE_W +: RW];
          end
        end
        ksel_pkg::CMD_DECIDE: begin
          if (ovf) res_status <= ksel_pkg::ST_OVF;
          else if (out_range) res_status <= ksel_pkg::ST_RANGE;
          else res_status <= ksel_pkg::ST_FOUND;
          res_pos  <= '0;
          tgt      <= target[IW-1:0];
          left     <= '0;
          right    <= IW'(count - CW'(1));
          cnt_i    <= '0;
          p1       <= 1'b0;
          scan_max <= (target != 0);
        end
        ksel_pkg::CMD_SCAN: begin
          p1     <= (cnt_i != count);
          p1_pos <= cnt_i[IW-1:0];
          if (cnt_i != count) cnt_i <= cnt_i + CW'(1);
          if (p1) begin
            if (p1_pos == '0 || (scan_max ? (key_rd > best_key) : (key_rd < best_key))) begin
              best_key <= key_rd;
              res_pos  <= p1_pos;
            end
          end
        end
        ksel_pkg::CMD_INIT: cnt_i <= cnt_i + CW'(1);
        ksel_pkg::CMD_RAND: begin
          seed   <= xs3;
          acc    <= '0;
          mcand  <= xs3;
          mplier <= ksel_pkg::MIX_MULT;
          bitcnt <= '0;
          rem    <= '0;
        end
        ksel_pkg::CMD_MUL: begin
          if (mplier[0]) acc <= acc + mcand;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          bitcnt <= bitcnt + 6'd1;
        end
        ksel_pkg::CMD_MOD: begin
          rem    <= (trial >= span) ? IW'(trial - span) : IW'(trial);
          acc    <= acc << 1;
          bitcnt <= bitcnt + 6'd1;
        end
        ksel_pkg::CMD_PIV_RD:  pidx <= left + rem;
        ksel_pkg::CMD_PIV_CAP: a_reg <= idx_rdata;
        ksel_pkg::CMD_PIV_SW1: pkey <= key_rd;
        ksel_pkg::CMD_PIV_SW2: begin
          cur   <= left;
          store <= left;
        end
        ksel_pkg::CMD_PART_VAL: x_reg <= idx_rdata;
        ksel_pkg::CMD_PART_CMP: if (!lt) cur <= cur + IW'(1);
        ksel_pkg::CMD_PART_SW: begin
          store <= store + IW'(1);
          cur   <= cur + IW'(1);
        end
        ksel_pkg::CMD_FIN_CAP: a_reg <= idx_rdata;
        ksel_pkg::CMD_FIN_SW1: b_reg <= idx_rdata;
        ksel_pkg::CMD_FIN_SW2: begin
          if (tgt == store) res_pos <= b_reg;
          else if (tgt < store) right <= store - IW'(1);
          else left <= store + IW'(1);
        end
        ksel_pkg::CMD_LAST_CAP: res_pos <= idx_rdata;
        ksel_pkg::CMD_OUT: begin
          if (out_free) begin
            m_tvalid   <= 1'b1;
            out_status <= res_status;
            out_pos    <= (res_status == ksel_pkg::ST_FOUND) ?
                          ksel_pkg::POS_W'(res_pos) : '0;
            count      <= '0;
            ovf        <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign m_tdata = {{(ksel_pkg::OUT_DATA_W-ksel_pkg::POS_W){1'b0}}, out_pos};
  assign m_tuser = out_status;

endmodule
